### sv/lrc_pkg.sv
// Shared types and constants for the LRU resource cache.
// No dependencies; imported by lrc_ram and lru_resource_cache_top.
package lrc_pkg;

   // Field width of key, id and use-clock ports
   localparam int FIELD_W = 64;

   // Default geometry
   localparam int DEF_ENTRIES  = 8;
   localparam int DEF_KEY_BITS = 64;

   // Operation codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

endpackage

### sv/lrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on lrc_pkg for the default field width and depth.
module lrc_ram
   import lrc_pkg::*;
#(
   parameter int WIDTH = FIELD_W,
   parameter int DEPTH = DEF_ENTRIES
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lru_resource_cache_top.sv
// Fully associative key-to-id cache with timestamp LRU replacement.
// A request is scanned one entry compared per cycle through the entry RAM read
// port, then written back in ST_FINISH and answered from ST_RESP. A new request
// is taken only in ST_IDLE, once the previous response has been accepted.
// Reset clears all valid bits and the use clock at once; no clearing pass.
// Depends on lrc_pkg and lrc_ram.
module lru_resource_cache_top
   import lrc_pkg::*;
#(
   parameter int ENTRIES  = DEF_ENTRIES,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [FIELD_W-1:0] req_key,
   input  logic [FIELD_W-1:0] req_new_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [FIELD_W-1:0] rsp_found_id,
   output logic [FIELD_W-1:0] rsp_displaced_id
);

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ENTRY_W = KEY_BITS + 2 * FIELD_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Sequencer
   state_type state_ff, state_in;

   // Request capture
   logic                func_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [FIELD_W-1:0]  new_id_ff;

   // Scan pipeline
   logic [CNT_W-1:0] issue_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   // Scan results
   logic               match_found_ff;
   logic [IDX_W-1:0]   match_idx_ff;
   logic [FIELD_W-1:0] match_id_ff;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [IDX_W-1:0]   lru_idx_ff;
   logic [FIELD_W-1:0] lru_stamp_ff;
   logic [FIELD_W-1:0] lru_id_ff;

   // Persistent state
   logic [ENTRIES-1:0] valid_ff;
   logic [FIELD_W-1:0] clock_ff;

   // Response registers
   logic               rsp_hit_ff;
   logic [FIELD_W-1:0] rsp_found_ff;
   logic [FIELD_W-1:0] rsp_evicted_ff;

   // RAM interface
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [KEY_BITS-1:0] rd_key;
   logic [FIELD_W-1:0]  rd_id;
   logic [FIELD_W-1:0]  rd_stamp;
   logic                key_eq;
   logic                stamp_lt;
   logic                last_chk;
   logic [FIELD_W-1:0]  clock_next;

   logic               req_acc;
   logic               rsp_acc;
   logic               do_write;
   logic [IDX_W-1:0]   slot;
   logic [FIELD_W-1:0] slot_evicted;
   logic [FIELD_W-1:0] wr_id;

   lrc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Split the entry word and run the shared compare unit
   assign rd_key     = rd_data[ENTRY_W-1 -: KEY_BITS];
   assign rd_id      = rd_data[2*FIELD_W-1 -: FIELD_W];
   assign rd_stamp   = rd_data[FIELD_W-1:0];
   assign key_eq     = (rd_key == key_ff);
   assign stamp_lt   = (rd_stamp < lru_stamp_ff);
   assign last_chk   = chk_vld_ff && (chk_idx_ff == LAST_IDX);
   assign clock_next = clock_ff + FIELD_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_chk) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   rd_en     = (issue_ff < CNT_W'(ENTRIES));
         ST_FINISH: ;
         ST_RESP:   rsp_valid = 1'b1;
         default:   ;
      endcase
   end

   assign rd_addr = issue_ff[IDX_W-1:0];

   // Pick the target slot and what it displaces
   always_comb begin
      do_write     = 1'b0;
      slot         = lru_idx_ff;
      slot_evicted = lru_id_ff;
      wr_id        = new_id_ff;
      if (func_ff == FUNC_LOOKUP) begin
         do_write = match_found_ff;
         slot     = match_idx_ff;
         wr_id    = match_id_ff;
      end else begin
         do_write = (new_id_ff != '0);
         if (match_found_ff) begin
            slot         = match_idx_ff;
            slot_evicted = match_id_ff;
         end else if (free_found_ff) begin
            slot         = free_idx_ff;
            slot_evicted = '0;
         end
      end
   end

   assign wr_en   = (state_ff == ST_FINISH) && do_write;
   assign wr_addr = slot;
   assign wr_data = {key_ff, wr_id, clock_next};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         clock_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SCAN) begin
            chk_vld_ff <= rd_en;
         end else begin
            chk_vld_ff <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[slot] <= 1'b1;
            clock_ff       <= clock_next;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Capture the request and start the scan
      if (req_acc) begin
         func_ff        <= req_func;
         key_ff         <= req_key[KEY_BITS-1:0];
         new_id_ff      <= req_new_id;
         issue_ff       <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end

      // Advance the read address
      if (rd_en) begin
         issue_ff   <= issue_ff + CNT_W'(1);
         chk_idx_ff <= issue_ff[IDX_W-1:0];
      end

      // Fold one entry into the scan results
      if ((state_ff == ST_SCAN) && chk_vld_ff) begin
         if (valid_ff[chk_idx_ff] && key_eq && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= chk_idx_ff;
            match_id_ff    <= rd_id;
         end
         if (!valid_ff[chk_idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= chk_idx_ff;
         end
         if ((chk_idx_ff == '0) || stamp_lt) begin
            lru_idx_ff   <= chk_idx_ff;
            lru_stamp_ff <= rd_stamp;
            lru_id_ff    <= rd_id;
         end
      end

      // Load the response
      if (state_ff == ST_FINISH) begin
         if (func_ff == FUNC_LOOKUP) begin
            rsp_hit_ff     <= match_found_ff;
            rsp_found_ff   <= match_found_ff ? match_id_ff : '0;
            rsp_evicted_ff <= '0;
         end else begin
            rsp_hit_ff     <= 1'b0;
            rsp_found_ff   <= '0;
            rsp_evicted_ff <= do_write ? slot_evicted : '0;
         end
      end
   end

   assign rsp_hit          = rsp_hit_ff;
   assign rsp_found_id     = rsp_found_ff;
   assign rsp_displaced_id = rsp_evicted_ff;

endmodule
